// ===== src/pbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsd_pkg
// Types, constants and the extent function shared by the BAR size decoder.
// ----------------------------------------------------------------------------
package pbsd_pkg;

  localparam logic [31:0] IO_MASK    = 32'h0000_FFFC;
  localparam logic [31:0] MEM32_MASK = 32'hFFFF_FFF0;
  localparam logic [63:0] MEM64_MASK = 64'hFFFF_FFFF_FFFF_FFF0;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam int unsigned IO_BIT     = 0;
  localparam int unsigned WIDE_BIT   = 2;

  localparam logic [2:0] SLOTS_BRIDGE = 3'd2;
  localparam logic [2:0] SLOTS_NORMAL = 3'd6;

  typedef enum logic [0:0] {
    REG_BRIDGE_HEADER  = 1'b0,
    REG_WIDE_ADDRESSES = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_IO      = 3'd1,
    KIND_MEM32   = 3'd2,
    KIND_MEM64   = 3'd3,
    KIND_PENDING = 3'd4,
    KIND_TOOWIDE = 3'd5
  } kind_t;

  typedef struct packed {
    logic [2:0]  slot_cnt;
    logic        upper_pending;
    logic        aborted;
    logic [31:0] low_base;
    logic [31:0] low_probe;
  } dev_state_t;

  typedef struct packed {
    logic [2:0]  slot;
    kind_t       kind;
    logic [63:0] base;
    logic [63:0] extent;
    logic        last;
  } bar_result_t;

  function automatic logic [63:0] bar_extent(input logic [63:0] base,
                                             input logic [63:0] readback,
                                             input logic [63:0] mask);
    logic [63:0] bits;
    logic [63:0] ext;
    bits = mask & readback;
    ext  = (bits & (~bits + 64'd1)) - 64'd1;
    if (bits == 64'd0) begin
      return 64'd0;
    end
    if (base == readback && ((base | ext) & mask) != mask) begin
      return 64'd0;
    end
    return ext;
  endfunction

endpackage

// ===== src/pci_bar_size_decoder_unit.sv =====
// pipeline: input register, then result register, from input beat to result beat
// throughput: one BAR slot beat per cycle while out_ready holds no stall;
// decode is one pass of mask and lowest-set-bit logic between the two registers
// reset: synchronous active-low rst_n clears valids, device state and config
// (bridge_header 0, wide_addresses 1)
// ----------------------------------------------------------------------------
// pci_bar_size_decoder_unit
// Decodes BAR original/probe pairs into kind, base and extent per slot.
// ----------------------------------------------------------------------------
module pci_bar_size_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_original_value,
  input  logic [31:0] in_probe_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_slot,
  output logic [2:0]  out_kind,
  output logic [63:0] out_base,
  output logic [63:0] out_extent,
  output logic        out_last
);
  import pbsd_pkg::*;

  logic        bridge_r;
  logic        wide_r;
  logic        s1_valid_r;
  logic [31:0] orig_r;
  logic [31:0] probe_r;
  dev_state_t  st_r;
  dev_state_t  st_nxt;
  bar_result_t res_nxt;
  bar_result_t res_r;
  logic        out_valid_r;
  logic        s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bridge_r <= 1'b0;
      wide_r   <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BRIDGE_HEADER:  bridge_r <= cfg_data[0];
        REG_WIDE_ADDRESSES: wide_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      orig_r  <= in_original_value;
      probe_r <= in_probe_value;
    end
  end

  pbsd_decode u_decode (
    .bridge_header  (bridge_r),
    .wide_addresses (wide_r),
    .original_value (orig_r),
    .probe_value    (probe_r),
    .st             (st_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_slot   = res_r.slot;
  assign out_kind   = res_r.kind;
  assign out_base   = res_r.base;
  assign out_extent = res_r.extent;
  assign out_last   = res_r.last;

  a_none_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == KIND_NONE |-> res_r.base == 64'd0)
    else $error("kind none with nonzero base");

  a_no_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.kind == KIND_PENDING || res_r.kind == KIND_TOOWIDE)
    |-> res_r.extent == 64'd0)
    else $error("extent reported for pending or too-wide slot");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.slot_cnt <= 3'd5)
    else $error("slot counter out of range");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.upper_pending && st_r.aborted))
    else $error("pending and aborted both set");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.last |-> res_r.slot == 3'd1 || res_r.slot == 3'd5)
    else $error("last flag on a middle slot");

endmodule

// ===== src/pbsd_decode.sv =====
// ----------------------------------------------------------------------------
// pbsd_decode
// Classifies one BAR slot beat and computes the device state after it.
// ----------------------------------------------------------------------------
module pbsd_decode (
  input  logic                     bridge_header,
  input  logic                     wide_addresses,
  input  logic [31:0]              original_value,
  input  logic [31:0]              probe_value,
  input  pbsd_pkg::dev_state_t     st,
  output pbsd_pkg::dev_state_t     st_nxt,
  output pbsd_pkg::bar_result_t    res
);
  import pbsd_pkg::*;

  logic [2:0]  count;
  logic [31:0] orig_m;
  logic [31:0] probe_m;
  logic [63:0] sp_up;
  logic [63:0] sz_up;
  logic [63:0] sp_io;
  logic [63:0] sp_32;
  logic [63:0] ext_up;
  logic [63:0] ext_io;
  logic [63:0] ext_32;

  assign count   = bridge_header ? SLOTS_BRIDGE : SLOTS_NORMAL;
  assign orig_m  = (original_value == ALL_ONES32) ? 32'd0 : original_value;
  assign probe_m = (probe_value == ALL_ONES32) ? 32'd0 : probe_value;

  assign sp_up  = {original_value, st.low_base};
  assign sz_up  = {probe_value, st.low_probe};
  assign sp_io  = {32'd0, orig_m & IO_MASK};
  assign sp_32  = {32'd0, orig_m & MEM32_MASK};
  assign ext_up = bar_extent(sp_up, sz_up, MEM64_MASK);
  assign ext_io = bar_extent(sp_io, {32'd0, probe_m}, {32'd0, IO_MASK});
  assign ext_32 = bar_extent(sp_32, {32'd0, probe_m & MEM32_MASK}, {32'd0, MEM32_MASK});

  always_comb begin
    dev_state_t cur;
    logic [2:0] s_inc;
    cur = st;
    if (st.slot_cnt >= count) begin
      cur.slot_cnt      = 3'd0;
      cur.upper_pending = 1'b0;
      cur.aborted       = 1'b0;
    end
    s_inc      = 3'(cur.slot_cnt + 3'd1);
    st_nxt     = cur;
    res.slot   = cur.slot_cnt;
    res.kind   = KIND_NONE;
    res.base   = 64'd0;
    res.extent = 64'd0;
    res.last   = (s_inc == count);

    if (cur.aborted) begin
      res.kind = KIND_NONE;
    end else if (cur.upper_pending) begin
      st_nxt.upper_pending = 1'b0;
      if (!wide_addresses && original_value != 32'd0) begin
        res.kind       = KIND_TOOWIDE;
        res.base       = sp_up;
        st_nxt.aborted = 1'b1;
      end else if (sp_up != 64'd0 && ext_up != 64'd0) begin
        res.kind   = KIND_MEM64;
        res.base   = sp_up;
        res.extent = ext_up;
      end
    end else if (orig_m[IO_BIT]) begin
      if (sp_io != 64'd0 && ext_io != 64'd0) begin
        res.kind   = KIND_IO;
        res.base   = sp_io;
        res.extent = ext_io;
      end
    end else if (orig_m[WIDE_BIT]) begin
      if (s_inc < count) begin
        st_nxt.low_base      = orig_m & MEM32_MASK;
        st_nxt.low_probe     = probe_m & MEM32_MASK;
        st_nxt.upper_pending = 1'b1;
        res.kind             = KIND_PENDING;
        res.base             = {32'd0, orig_m & MEM32_MASK};
      end
    end else begin
      if (sp_32 != 64'd0 && ext_32 != 64'd0) begin
        res.kind   = KIND_MEM32;
        res.base   = sp_32;
        res.extent = ext_32;
      end
    end

    if (s_inc >= count) begin
      st_nxt.slot_cnt      = 3'd0;
      st_nxt.upper_pending = 1'b0;
      st_nxt.aborted       = 1'b0;
    end else begin
      st_nxt.slot_cnt = s_inc;
    end
  end

endmodule
